[rtl/casp_pkg.sv]
package casp_pkg;

	localparam int CELLS_W     = 64;
	localparam int ROW_NUM_W   = 10;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 80;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_ADDR_W-1:0] REG_RULE_MODE    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FORCE_BORDER = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_COLS_IN_USE  = 2'd2;

	localparam logic [CFG_DATA_W-1:0] COLS_RESET = 7'd64;
	localparam logic [CFG_DATA_W-1:0] MIN_COLS   = 7'd5;

	// 3x3 count that makes a wall, 5x5 count at or below which a cell becomes wall
	localparam logic [4:0] WALL_MIN = 5'd5;
	localparam logic [4:0] OPEN_MAX = 5'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CELL,
		ST_PUT
	} seq_state_t;

	function automatic logic [2:0] cnt5(input logic [4:0] v);
		return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]) + 3'(v[4]);
	endfunction

endpackage

[rtl/cave_automaton_smoothing_pass_unit.sv]
// one input row per item; an item emits no row or one row, a bottom row up to three rows
// each emitted row: one window load, then one cell per cycle through the shared 5x5 counting
// unit over the W = clamped cols_in_use columns, then into the output register once it has room
// no new row is taken until the emitted rows of the current one are in the output register;
// the first two rows of a map, unless one is the bottom row, are only held and emit nothing
// reset (arst_n low): idle, rows and row count cleared, output empty, config at reset values
module cave_automaton_smoothing_pass_unit #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [casp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [casp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [casp_pkg::IN_TDATA_W-1:0]     s_tdata,   // [63:0] row_cells
	input  logic                                s_tlast,   // last_row
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [casp_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [63:0] new_cells, [73:64] row_number, zeros
	output logic                                m_tlast    // last_of_run
);

	localparam int CW      = $clog2(MAX_COLS);
	localparam int SW      = MAX_COLS + 4;
	localparam int ROW_SAT = ((MAX_ROWS - 1) < 1023) ? (MAX_ROWS - 1) : 1023;
	localparam logic [casp_pkg::ROW_NUM_W-1:0] ROW_SAT_V = casp_pkg::ROW_NUM_W'(ROW_SAT);
	localparam logic [casp_pkg::CFG_DATA_W-1:0] MAXC     = casp_pkg::CFG_DATA_W'(MAX_COLS);

	casp_pkg::seq_state_t state_q, state_d;

	logic                                rule_mode_q;
	logic                                force_border_q;
	logic [casp_pkg::CFG_DATA_W-1:0]     cols_q;

	logic [MAX_COLS-1:0]                 upd_q [2];
	logic [MAX_COLS-1:0]                 pend_q [2];
	logic [casp_pkg::ROW_NUM_W-1:0]      rows_seen_q;

	logic [casp_pkg::ROW_NUM_W-1:0]      k_q;
	logic                                last_q;
	logic [1:0]                          s_q;
	logic [CW-1:0]                       j_q;
	logic [4:0]                          inc_q;
	logic [MAX_COLS-1:0]                 orig_q;
	logic [SW-1:0]                       sh_q [5];
	logic [MAX_COLS-1:0]                 res_q;

	logic                                ovalid_q;
	logic [MAX_COLS-1:0]                 ocells_q;
	logic [casp_pkg::ROW_NUM_W-1:0]      orow_q;
	logic                                olast_q;

	logic [casp_pkg::CFG_DATA_W-1:0]     w;
	logic [MAX_COLS-1:0]                 wmask, cm, bmask;
	logic [MAX_COLS-1:0]                 in_row;
	logic                                accept, emits_none, room;
	logic                                ld_row, step, put, done;
	logic [1:0]                          s_first, s_final;
	logic signed [11:0]                  idx;
	logic signed [11:0]                  y_d [5];
	logic [MAX_COLS-1:0]                 row_sel [5];
	logic [4:0]                          cnt_ok, inc_sel;
	logic [4:0]                          c5, c3;
	logic                                wall;
	logic [SW-1:0]                       sh2_wr;
	logic                                edge_row;
	logic [MAX_COLS-1:0]                 cells_now, cells_out;
	logic [casp_pkg::ROW_NUM_W-1:0]      row_num;
	logic [casp_pkg::CELLS_W-1:0]        ocells_ext;

	// clamped width and column masks
	always_comb begin
		if (cols_q < casp_pkg::MIN_COLS) begin
			w = casp_pkg::MIN_COLS;
		end else if (cols_q > MAXC) begin
			w = MAXC;
		end else begin
			w = cols_q;
		end
		for (int x = 0; x < MAX_COLS; x++) begin
			wmask[x] = x < int'(w);
			cm[x]    = (x >= 1) && (x + 2 <= int'(w));
			bmask[x] = (x < 2) || (x + 2 >= int'(w));
		end
	end

	assign in_row     = s_tdata[MAX_COLS-1:0] & wmask;
	assign accept     = s_tvalid && s_tready;
	assign emits_none = !s_tlast && (rows_seen_q < 10'd2);
	assign s_first    = (s_tlast && rows_seen_q < 10'd2) ? (2'd2 - rows_seen_q[1:0]) : 2'd0;
	assign s_final    = last_q ? 2'd2 : 2'd0;
	assign room       = !ovalid_q || m_tready;
	assign idx        = $signed({2'b00, k_q}) + $signed({10'd0, s_q}) - 12'sd2;

	// window rows for the row being smoothed: two updated above, center and up to two originals below
	always_comb begin
		row_sel[0] = upd_q[0];
		row_sel[1] = upd_q[1];
		unique case (s_q)
			2'd0: begin
				row_sel[2] = pend_q[0];
				row_sel[3] = pend_q[1];
				row_sel[4] = orig_q;
			end
			2'd1: begin
				row_sel[2] = pend_q[1];
				row_sel[3] = orig_q;
				row_sel[4] = '0;
			end
			default: begin
				row_sel[2] = orig_q;
				row_sel[3] = '0;
				row_sel[4] = '0;
			end
		endcase
		// the bottom row itself and rows past it do not count
		cnt_ok[0] = 1'b1;
		cnt_ok[1] = 1'b1;
		cnt_ok[2] = last_q ? (s_q < 2'd2) : 1'b1;
		cnt_ok[3] = last_q ? (s_q == 2'd0) : (s_q <= 2'd1);
		cnt_ok[4] = !last_q && (s_q == 2'd0);
		for (int d = 0; d < 5; d++) begin
			y_d[d]     = idx + 12'(d) - 12'sd2;
			inc_sel[d] = cnt_ok[d] && (y_d[d] >= 12'sd1);
		end
	end

	// shared counting unit: 5x5 and 3x3 wall counts at the window centered on column j
	always_comb begin
		c5 = 5'(casp_pkg::cnt5(sh_q[0][4:0])) + 5'(casp_pkg::cnt5(sh_q[1][4:0]))
		   + 5'(casp_pkg::cnt5(sh_q[2][4:0])) + 5'(casp_pkg::cnt5(sh_q[3][4:0]))
		   + 5'(casp_pkg::cnt5(sh_q[4][4:0]));
		c3 = 5'(casp_pkg::cnt5({2'b00, sh_q[1][3:1]}))
		   + 5'(casp_pkg::cnt5({2'b00, sh_q[2][3:1]}))
		   + 5'(casp_pkg::cnt5({2'b00, sh_q[3][3:1]}));
		wall = (c3 >= casp_pkg::WALL_MIN) || (!rule_mode_q && c5 <= casp_pkg::OPEN_MAX);
		// updated cell goes back into the center row so cells to its right see it
		sh2_wr    = sh_q[2];
		sh2_wr[2] = wall && cm[j_q] && inc_q[2];
	end

	always_comb begin
		cells_now = res_q & wmask;
		edge_row  = ((k_q < ROW_SAT_V) && (idx <= 12'sd1)) || (last_q && s_q >= 2'd1);
		if (!force_border_q) begin
			cells_out = cells_now;
		end else if (edge_row) begin
			cells_out = wmask;
		end else begin
			cells_out = (cells_now | bmask) & wmask;
		end
		row_num = (k_q >= ROW_SAT_V) ? ROW_SAT_V : idx[casp_pkg::ROW_NUM_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			casp_pkg::ST_IDLE: begin
				if (accept && !emits_none) begin
					state_d = casp_pkg::ST_LOAD;
				end
			end
			casp_pkg::ST_LOAD: begin
				state_d = casp_pkg::ST_CELL;
			end
			casp_pkg::ST_CELL: begin
				if (7'(j_q) == w - 7'd1) begin
					state_d = casp_pkg::ST_PUT;
				end
			end
			casp_pkg::ST_PUT: begin
				if (room) begin
					state_d = (s_q == s_final) ? casp_pkg::ST_IDLE : casp_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = casp_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = state_q == casp_pkg::ST_IDLE;
		ld_row   = state_q == casp_pkg::ST_LOAD;
		step     = state_q == casp_pkg::ST_CELL;
		put      = (state_q == casp_pkg::ST_PUT) && room;
		done     = put && (s_q == s_final);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= casp_pkg::ST_IDLE;
			rule_mode_q    <= 1'b0;
			force_border_q <= 1'b0;
			cols_q         <= casp_pkg::COLS_RESET;
			upd_q[0]       <= '0;
			upd_q[1]       <= '0;
			pend_q[0]      <= '0;
			pend_q[1]      <= '0;
			rows_seen_q    <= '0;
			k_q            <= '0;
			last_q         <= 1'b0;
			s_q            <= '0;
			j_q            <= '0;
			inc_q          <= '0;
			ovalid_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					casp_pkg::REG_RULE_MODE:    rule_mode_q    <= cfg_wdata[0];
					casp_pkg::REG_FORCE_BORDER: force_border_q <= cfg_wdata[0];
					casp_pkg::REG_COLS_IN_USE:  cols_q         <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (accept) begin
				k_q    <= rows_seen_q;
				last_q <= s_tlast;
				s_q    <= s_first;
				if (emits_none) begin
					pend_q[0]   <= pend_q[1];
					pend_q[1]   <= in_row;
					rows_seen_q <= rows_seen_q + 10'd1;
				end
			end
			if (ld_row) begin
				j_q   <= '0;
				inc_q <= inc_sel;
			end
			if (step) begin
				j_q <= j_q + CW'(1);
			end
			if (put) begin
				// the end of a map clears the updated rows for the next one
				if (done && last_q) begin
					upd_q[0] <= '0;
					upd_q[1] <= '0;
				end else begin
					upd_q[0] <= upd_q[1];
					upd_q[1] <= cells_now;
				end
				s_q      <= s_q + 2'd1;
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			if (done) begin
				if (last_q) begin
					pend_q[0]   <= '0;
					pend_q[1]   <= '0;
					rows_seen_q <= '0;
				end else begin
					pend_q[0] <= pend_q[1];
					pend_q[1] <= orig_q;
					if (rows_seen_q < ROW_SAT_V) begin
						rows_seen_q <= rows_seen_q + 10'd1;
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			orig_q <= in_row;
		end
		if (ld_row) begin
			for (int d = 0; d < 5; d++) begin
				sh_q[d] <= inc_sel[d] ? {2'b00, row_sel[d] & cm, 2'b00} : '0;
			end
		end
		if (step) begin
			res_q[j_q] <= wall;
			sh_q[0]    <= sh_q[0] >> 1;
			sh_q[1]    <= sh_q[1] >> 1;
			sh_q[2]    <= sh2_wr >> 1;
			sh_q[3]    <= sh_q[3] >> 1;
			sh_q[4]    <= sh_q[4] >> 1;
		end
		if (put) begin
			ocells_q <= cells_out;
			orow_q   <= row_num;
			olast_q  <= s_q == s_final;
		end
	end

	always_comb begin
		ocells_ext                 = '0;
		ocells_ext[MAX_COLS-1:0]   = ocells_q;
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {6'd0, orow_q, ocells_ext};
	assign m_tlast  = olast_q;

endmodule

[rtl/casp_checker.sv]
module casp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             s_tlast,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [casp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// the bottom row always emits, so the block is busy right after taking it
	a_bottom_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input ready right after bottom row");

	// a flush is still running while a non-final row of it waits
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a flush");

	// padding above row_number stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[79:74] == 6'd0)
		else $error("output padding not zero");

endmodule

bind cave_automaton_smoothing_pass_unit casp_checker u_casp_checker (.*);

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 1024;
	localparam int ROW_LIMIT = (MAX_ROWS - 1 < 1023) ? MAX_ROWS - 1 : 1023;
	// worst case for a bottom row: three emitted rows
	localparam int DRAIN_CYCLES = 3 * (MAX_COLS + 2) + 16;
	localparam logic RULE_BOTH = 1'b0;
	localparam logic RULE_DENSE_ONLY = 1'b1;
	localparam logic [casp_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

	typedef logic [casp_pkg::CELLS_W-1:0] row_t;
	typedef struct packed {
		row_t cells;
		logic [casp_pkg::ROW_NUM_W-1:0] row_num;
		logic tail;
	} out_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [casp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [casp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [casp_pkg::IN_TDATA_W-1:0] s_tdata = '0;   // [63:0] row_cells
	logic s_tlast = 1'b0;                            // last_row
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [casp_pkg::OUT_TDATA_W-1:0] m_tdata;       // [63:0] new_cells, [73:64] row_number, zeros
	logic m_tlast;                                   // last_of_run

	// predictor copy of the registers and the held rows
	logic cfg_rule = RULE_BOTH;
	logic cfg_border = 1'b0;
	logic [casp_pkg::CFG_DATA_W-1:0] cfg_cols = casp_pkg::COLS_RESET;
	row_t done_rows [2] = '{'0, '0};
	row_t held_rows [2] = '{'0, '0};
	int row_count = 0;

	out_row_t smoothed_rows_due [$];
	int mismatches = 0;
	int rows_sent = 0;
	int rows_checked = 0;
	int maps_sent = 0;
	bit tx_idle = 1'b1;
	bit rx_stall = 1'b1;

	cave_automaton_smoothing_pass_unit #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[cave_automaton_smoothing_pass_unit] ERROR");
		$finish;
	end

	function automatic int cols_clamped();
		int w;
		w = int'(cfg_cols);
		if (w < int'(casp_pkg::MIN_COLS)) w = int'(casp_pkg::MIN_COLS);
		if (w > MAX_COLS) w = MAX_COLS;
		return w;
	endfunction

	function automatic row_t width_mask(int w);
		return (w >= casp_pkg::CELLS_W) ? '1 : ((row_t'(1) << w) - row_t'(1));
	endfunction

	// walls in columns j-r..j+r, clipped to the inner columns 1..w-2
	function automatic int span_walls(row_t row, int j, int r, int w);
		int lo, hi, n, b;
		lo = (j - r < 1) ? 1 : j - r;
		hi = (j + r > w - 2) ? w - 2 : j + r;
		n = 0;
		for (b = lo; b <= hi; b++) n += row[b];
		return n;
	endfunction

	// win holds rows -2..+2 around the center; the center is rewritten cell by cell
	function automatic row_t smooth_row(logic [4:0][casp_pkg::CELLS_W-1:0] win,
			logic [4:0] counted, int w);
		row_t cur, src;
		int c3, c5, j, d;
		cur = win[2];
		for (j = 0; j < w; j++) begin
			c3 = 0;
			c5 = 0;
			for (d = 0; d < 5; d++) begin
				src = (d == 2) ? cur : row_t'(win[d]);
				if (counted[d]) begin
					c5 += span_walls(src, j, 2, w);
					if (d >= 1 && d <= 3) c3 += span_walls(src, j, 1, w);
				end
			end
			cur[j] = (c3 >= int'(casp_pkg::WALL_MIN)) ||
				(cfg_rule == RULE_BOTH && c5 <= int'(casp_pkg::OPEN_MAX));
		end
		return cur & width_mask(w);
	endfunction

	task automatic smooth_and_queue(row_t in_cells, logic bottom);
		int w, k, first, upper, idx, off, s, d;
		row_t wmask, cells;
		row_t orig [3];
		logic [4:0][casp_pkg::CELLS_W-1:0] win;
		logic [4:0] counted;
		logic edge_row;
		out_row_t r;
		w = cols_clamped();
		wmask = width_mask(w);
		k = row_count;
		orig[0] = held_rows[0];
		orig[1] = held_rows[1];
		orig[2] = in_cells & wmask;
		if (bottom) first = (k >= 2) ? 0 : 2 - k;
		else first = (k >= 2) ? 0 : 3;
		upper = bottom ? 2 : 0;
		for (s = first; s <= upper; s++) begin
			idx = k - 2 + s;
			for (d = 0; d < 5; d++) begin
				off = d - 2;
				if (off < 0) win[d] = done_rows[d];
				else if (s + off <= 2) win[d] = orig[s + off];
				else win[d] = '0;
				// the bottom row, rows below it and the top row are not counted
				counted[d] = (idx + off >= 1) && (bottom ? (s + off < 2) : (s + off <= 2));
			end
			cells = smooth_row(win, counted, w);
			done_rows[0] = done_rows[1];
			done_rows[1] = cells;
			if (cfg_border) begin
				edge_row = (k < ROW_LIMIT && idx <= 1) || (bottom && s >= 1);
				if (edge_row) cells = wmask;
				else cells |= row_t'(3) | (row_t'(3) << (w - 2));
			end
			r.cells = cells & wmask;
			r.row_num = (k >= ROW_LIMIT) ? casp_pkg::ROW_NUM_W'(ROW_LIMIT)
				: casp_pkg::ROW_NUM_W'(idx);
			r.tail = (s == upper);
			smoothed_rows_due.push_back(r);
		end
		if (bottom) begin
			done_rows = '{'0, '0};
			held_rows = '{'0, '0};
			row_count = 0;
		end else begin
			held_rows[0] = orig[1];
			held_rows[1] = orig[2];
			if (row_count < ROW_LIMIT) row_count++;
		end
	endtask

	// called in the time step of a rising edge
	task automatic send_row(row_t cells, logic bottom);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cells;
		s_tlast <= bottom;
		do @(posedge clk); while (!s_tready);
		smooth_and_queue(cells, bottom);
		rows_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (smoothed_rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [casp_pkg::CFG_ADDR_W-1:0] addr,
			logic [casp_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (addr)
			casp_pkg::REG_RULE_MODE: begin
				cfg_rule = value[0];
			end
			casp_pkg::REG_FORCE_BORDER: begin
				cfg_border = value[0];
			end
			casp_pkg::REG_COLS_IN_USE: begin
				cfg_cols = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_config(logic rule, logic border, logic [casp_pkg::CFG_DATA_W-1:0] cols);
		drain();
		write_reg(casp_pkg::REG_RULE_MODE, casp_pkg::CFG_DATA_W'(rule));
		write_reg(casp_pkg::REG_FORCE_BORDER, casp_pkg::CFG_DATA_W'(border));
		write_reg(casp_pkg::REG_COLS_IN_USE, cols);
	endtask

	function automatic row_t random_row(int density);
		row_t a, b, c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case (density)
			0: return a & b & c;
			1: return a & b;
			2: return a;
			3: return a | b;
			4: return a | b | c;
			default: return ($urandom_range(0, 1) == 0) ? '0 : '1;
		endcase
	endfunction

	function automatic logic [casp_pkg::CFG_DATA_W-1:0] random_width();
		case ($urandom_range(0, 5))
			0: return casp_pkg::COLS_RESET;
			1: return casp_pkg::CFG_DATA_W'($urandom_range(0, 4));
			2: return casp_pkg::CFG_DATA_W'($urandom_range(65, 127));
			3, 4: return casp_pkg::CFG_DATA_W'($urandom_range(5, 12));
			default: return casp_pkg::CFG_DATA_W'($urandom_range(5, 64));
		endcase
	endfunction

	task automatic send_map(int height, int density);
		int i;
		for (i = 0; i < height; i++) begin
			// a stray row of another density now and then
			if ($urandom_range(0, 7) == 0) send_row(random_row($urandom_range(0, 5)),
				i == height - 1);
			else send_row(random_row(density), i == height - 1);
		end
		maps_sent++;
	endtask

	// one-, two- and three-row maps flush everything on the bottom row
	task automatic test_short_maps();
		send_row('1, 1'b1);
		send_row('0, 1'b0);
		send_row('1, 1'b1);
		send_row({32{2'b10}}, 1'b0);
		send_row({32{2'b01}}, 1'b0);
		send_row('1, 1'b1);
		maps_sent += 3;
	endtask

	task automatic test_extremes();
		send_row('0, 1'b0);
		send_row('1, 1'b0);
		send_row({32{2'b10}}, 1'b0);
		send_row({32{2'b01}}, 1'b0);
		send_row('0, 1'b1);
		maps_sent++;
	endtask

	// both rules, border forcing, and widths below and above the legal range
	task automatic test_settings();
		set_config(RULE_DENSE_ONLY, 1'b1, casp_pkg::MIN_COLS);
		send_map(4, 2);
		set_config(RULE_BOTH, 1'b1, '0);
		write_reg(REG_UNUSED, '1);
		send_map(3, 3);
		set_config(RULE_DENSE_ONLY, 1'b0, '1);
		send_map(3, 1);
	endtask

	task automatic test_random_maps(int item_goal);
		int goal, height;
		goal = rows_sent + item_goal;
		while (rows_sent < goal) begin
			if ($urandom_range(0, 2) == 0)
				set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), random_width());
			height = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
			send_map(height, $urandom_range(0, 5));
		end
	endtask

	always @(posedge clk) begin : check_rows
		out_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (smoothed_rows_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row: cells %h row %0d last %b",
						m_tdata[casp_pkg::CELLS_W-1:0],
						m_tdata[casp_pkg::CELLS_W +: casp_pkg::ROW_NUM_W], m_tlast);
			end else begin
				want = smoothed_rows_due.pop_front();
				rows_checked++;
				if (m_tdata[casp_pkg::CELLS_W-1:0] !== want.cells ||
						m_tdata[casp_pkg::CELLS_W +: casp_pkg::ROW_NUM_W] !== want.row_num ||
						m_tdata[casp_pkg::OUT_TDATA_W-1:casp_pkg::CELLS_W+casp_pkg::ROW_NUM_W]
							!== '0 ||
						m_tlast !== want.tail) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"row mismatch: expected cells %h row %0d last %b,",
							" got %h %0d %b pad %h"},
							want.cells, want.row_num, want.tail,
							m_tdata[casp_pkg::CELLS_W-1:0],
							m_tdata[casp_pkg::CELLS_W +: casp_pkg::ROW_NUM_W], m_tlast,
							m_tdata[casp_pkg::OUT_TDATA_W-1:
								casp_pkg::CELLS_W+casp_pkg::ROW_NUM_W]);
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_stall && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_maps();
		test_extremes();
		test_settings();
		test_random_maps(240);
		tx_idle = 1'b0;
		rx_stall = 1'b0;
		test_random_maps(60);
		drain();
		$display("%0d input rows in %0d maps, %0d output rows checked", rows_sent, maps_sent,
			rows_checked);
		$display("both rules, border forcing, clamped widths and short maps under random stalls");
		if (mismatches == 0 && smoothed_rows_due.size() == 0) begin
			$display("[cave_automaton_smoothing_pass_unit] OK");
		end else begin
			$display("[cave_automaton_smoothing_pass_unit] ERROR");
		end
		$finish;
	end

endmodule
